### rtl/owrf_pkg.sv
// Shared types and constants for the overwrite-oldest ring FIFO.
`timescale 1ns / 1ps

package owrf_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 64;
    localparam int MAX_POP        = 16;

    localparam int CMD_W  = 3;
    localparam int WORD_W = 64;
    localparam int REQ_W  = 5;
    localparam int OCC_W  = 5;
    localparam int CAP_W  = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MPOP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] frame_data;
        logic              frame_flag;
        logic [REQ_W-1:0]  pop_request;
    } owrf_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] out_data;
        logic              out_present;
        logic              out_last;
        logic              overwrote_oldest;
        logic [OCC_W-1:0]  occupancy;
        logic              is_empty;
        logic              is_full;
    } owrf_out_t;

endpackage

### rtl/overwrite_ring_fifo_core.sv
// Overwrite-oldest ring FIFO of flagged frame words with a small command sequencer.
// Push, clear, unknown commands and pop, peek or multi pop with nothing to read answer straight from idle.
// Pop and peek with a live entry pass through a read state for the registered slot read.
// Multi pop: each removed entry takes a read state, then an evaluate state, and a close-out state ends the run.
// A new beat is taken only with the sequencer idle, the result register free and no capacity write.
// Reset clears pointers and count and sets capacity to DEPTH; slot storage is not cleared.
`timescale 1ns / 1ps

module overwrite_ring_fifo_core
    import owrf_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  owrf_in_t         in_item,
    output logic             res_valid,
    input  logic             res_stall,
    output owrf_out_t        res_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > REQ_W) ? CNT_W : REQ_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_MADDR = 3'd2;
    localparam logic [2:0] S_MEVAL = 3'd3;
    localparam logic [2:0] S_MEND  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [PTR_W-1:0]      rp_reg, rp_next;
    logic [PTR_W-1:0]      wp_reg, wp_next;
    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic [CNT_W-1:0]      cap_reg, cap_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  peek_reg, peek_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [DATA_WIDTH-1:0] pend_data_reg, pend_data_next;
    logic                  res_valid_reg;
    owrf_out_t             res_reg;

    logic [DATA_WIDTH:0]   slot_mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  rd_flag_reg;
    logic [PTR_W-1:0]      rd_addr;
    logic                  rd_en;
    logic                  mem_we;

    logic                  out_free;
    logic                  in_fire;
    logic                  emit;
    logic [DATA_WIDTH-1:0] emit_data;
    logic                  emit_present;
    logic                  emit_last;
    logic                  emit_over;

    logic [CMP_W-1:0]      req_sat;
    logic [CMP_W-1:0]      fill_ext;
    logic [CNT_W-1:0]      pop_n;
    logic [CMP_W-1:0]      cap_raw;
    logic [CNT_W-1:0]      cap_cfg;
    logic [PTR_W-1:0]      peek_idx;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                             input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] p1;
        p1 = CNT_W'({1'b0, p}) + CNT_W'(1);
        return (p1 == cap) ? '0 : PTR_W'(p1);
    endfunction

    assign out_free = !res_valid_reg || !res_stall;
    assign in_stall = !((state_reg == S_IDLE) && out_free) || cfg_wr_en;
    assign in_fire  = in_valid && !in_stall;
    assign rd_en    = (state_reg == S_IDLE) || (state_reg == S_MADDR);

    assign req_sat  = (CMP_W'(in_item.pop_request) > CMP_W'(MAX_POP))
                      ? CMP_W'(MAX_POP) : CMP_W'(in_item.pop_request);
    assign fill_ext = CMP_W'(fill_reg);
    assign pop_n    = (req_sat < fill_ext) ? CNT_W'(req_sat) : fill_reg;
    assign peek_idx = (wp_reg == '0) ? PTR_W'(cap_reg - CNT_W'(1)) : wp_reg - PTR_W'(1);

    assign cap_raw  = CMP_W'(cfg_wr_data);
    assign cap_cfg  = (cap_raw == '0) ? CNT_W'(1)
                    : (cap_raw > CMP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_raw);

    always_comb
    begin
        state_next      = state_reg;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        fill_next       = fill_reg;
        cap_next        = cap_reg;
        cnt_next        = cnt_reg;
        peek_next       = peek_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        rd_addr         = rp_reg;
        mem_we          = 1'b0;
        emit            = 1'b0;
        emit_data       = '0;
        emit_present    = 1'b0;
        emit_last       = 1'b1;
        emit_over       = 1'b0;

        if (cfg_wr_en)
        begin
            cap_next  = cap_cfg;
            rp_next   = '0;
            wp_next   = '0;
            fill_next = '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_item.cmd == CMD_PEEK)
                    begin
                        rd_addr = peek_idx;
                    end
                    if (in_fire)
                    begin
                        case (in_item.cmd)
                            CMD_PUSH:
                            begin
                                mem_we  = 1'b1;
                                wp_next = adv(wp_reg, cap_reg);
                                if (fill_reg < cap_reg)
                                begin
                                    fill_next = fill_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    rp_next   = adv(rp_reg, cap_reg);
                                    emit_over = 1'b1;
                                end
                                emit = 1'b1;
                            end
                            CMD_POP:
                            begin
                                if (fill_reg != '0)
                                begin
                                    rp_next    = adv(rp_reg, cap_reg);
                                    fill_next  = fill_reg - CNT_W'(1);
                                    peek_next  = 1'b0;
                                    state_next = S_RD;
                                end
                                else
                                begin
                                    emit = 1'b1;
                                end
                            end
                            CMD_MPOP:
                            begin
                                if (pop_n == '0)
                                begin
                                    emit = 1'b1;
                                end
                                else
                                begin
                                    fill_next       = fill_reg - pop_n;
                                    cnt_next        = pop_n;
                                    pend_valid_next = 1'b0;
                                    state_next      = S_MADDR;
                                end
                            end
                            CMD_PEEK:
                            begin
                                if (fill_reg != '0)
                                begin
                                    peek_next  = 1'b1;
                                    state_next = S_RD;
                                end
                                else
                                begin
                                    emit = 1'b1;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                rp_next   = '0;
                                wp_next   = '0;
                                fill_next = '0;
                                emit      = 1'b1;
                            end
                            default:
                            begin
                                emit = 1'b1;
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    if (out_free)
                    begin
                        emit         = 1'b1;
                        emit_present = !peek_reg || rd_flag_reg;
                        emit_data    = emit_present ? rd_data_reg : '0;
                        state_next   = S_IDLE;
                    end
                end
                S_MADDR:
                begin
                    state_next = S_MEVAL;
                end
                S_MEVAL:
                begin
                    if (!(rd_flag_reg && pend_valid_reg && !out_free))
                    begin
                        rp_next  = adv(rp_reg, cap_reg);
                        cnt_next = cnt_reg - CNT_W'(1);
                        if (rd_flag_reg)
                        begin
                            if (pend_valid_reg)
                            begin
                                emit         = 1'b1;
                                emit_present = 1'b1;
                                emit_data    = pend_data_reg;
                                emit_last    = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_data_next  = rd_data_reg;
                        end
                        state_next = (cnt_reg == CNT_W'(1)) ? S_MEND : S_MADDR;
                    end
                end
                S_MEND:
                begin
                    if (out_free)
                    begin
                        emit            = 1'b1;
                        emit_present    = pend_valid_reg;
                        emit_data       = pend_valid_reg ? pend_data_reg : '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rp_reg         <= '0;
            wp_reg         <= '0;
            fill_reg       <= '0;
            cap_reg        <= CNT_W'(DEPTH);
            cnt_reg        <= '0;
            peek_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rp_reg         <= rp_next;
            wp_reg         <= wp_next;
            fill_reg       <= fill_next;
            cap_reg        <= cap_next;
            cnt_reg        <= cnt_next;
            peek_reg       <= peek_next;
            pend_valid_reg <= pend_valid_next;
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_data_reg <= pend_data_next;
        if (emit)
        begin
            res_reg.out_data         <= WORD_W'(emit_data);
            res_reg.out_present      <= emit_present;
            res_reg.out_last         <= emit_last;
            res_reg.overwrote_oldest <= emit_over;
            res_reg.occupancy        <= OCC_W'(fill_next);
            res_reg.is_empty         <= (fill_next == '0);
            res_reg.is_full          <= (fill_next == cap_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[wp_reg] <= {in_item.frame_flag, in_item.frame_data[DATA_WIDTH-1:0]};
        end
        if (rd_en)
        begin
            {rd_flag_reg, rd_data_reg} <= slot_mem[rd_addr];
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

`ifndef SYNTHESIS
    a_fill_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= cap_reg)
        else $error("fill count above capacity");

    a_ptr_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'({1'b0, rp_reg}) < cap_reg) && (CNT_W'({1'b0, wp_reg}) < cap_reg))
        else $error("ring pointer outside capacity");

    a_pend_in_mpop: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == S_MADDR || state_reg == S_MEVAL
                            || state_reg == S_MEND))
        else $error("pending multi pop beat outside multi pop");

    a_mend_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MEND) |-> (cnt_reg == '0))
        else $error("multi pop closed with entries left");
`endif

endmodule
